[rtl/clcd_pkg.sv]
package clcd_pkg;

   // request operation codes
   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_CMD   = 3'd1;
   localparam logic [2:0] OP_DATA  = 3'd2;
   localparam logic [2:0] OP_GOTO  = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_PULSE_WAIT      = 3'd0;
   localparam logic [2:0] CSR_SHORT_WAIT      = 3'd1;
   localparam logic [2:0] CSR_LONG_WAIT       = 3'd2;
   localparam logic [2:0] CSR_POWERUP_WAIT    = 3'd3;
   localparam logic [2:0] CSR_FIRST_WAKE_WAIT = 3'd4;
   localparam logic [2:0] CSR_WAKE_WAIT       = 3'd5;

   localparam int WAIT_W  = 24;
   localparam int EVENT_W = 26;

   // lcd command bytes
   localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] DDRAM_LINE0    = 8'h80;
   localparam logic [7:0] DDRAM_LINE1    = 8'hC0;
   localparam logic [7:0] LONG_CMD_LIMIT = 8'h04;
   localparam logic [7:0] ROW_FIRST      = 8'h01;
   localparam logic [3:0] WAKE_NIB       = 4'h3;
   localparam logic [3:0] WAKE_NIB_4BIT  = 4'h2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POWER,
      ST_WAKE,
      ST_BYTE
   } state_type;

   typedef enum logic [2:0] {
      EV_POWER,
      EV_WAKE_HI,
      EV_WAKE_LO_FIRST,
      EV_WAKE_LO,
      EV_BYTE_HI_EN,
      EV_BYTE_HI_DIS,
      EV_BYTE_LO_EN,
      EV_BYTE_LO_DIS
   } evt_type;

   typedef enum logic [1:0] {
      EXTRA_SHORT,
      EXTRA_LONG,
      EXTRA_DOUBLE
   } extra_type;

   typedef struct packed {
      logic       load_req;
      logic       load_init;
      logic [1:0] init_idx;
      logic       emit;
      evt_type    evt;
      logic       wake_two;
      logic       last;
   } ctrl_cmd_type;

endpackage

[rtl/clcd_ctrl.sv]
module clcd_ctrl
   import clcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [2:0]   req_operation,
   output logic         busy,
   output ctrl_cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [2:0] wake_ff, wake_in;
   logic [1:0] phase_ff, phase_in;
   logic       init_ff, init_in;
   logic [1:0] icmd_ff, icmd_in;
   logic       take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wake_ff  <= '0;
         phase_ff <= '0;
         init_ff  <= 1'b0;
         icmd_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wake_ff  <= wake_in;
         phase_ff <= phase_in;
         init_ff  <= init_in;
         icmd_ff  <= icmd_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      wake_in  = wake_ff;
      phase_in = phase_ff;
      init_in  = init_ff;
      icmd_in  = icmd_ff;
      cmd      = '0;
      take     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            take = 1'b1;
         end
         ST_POWER: begin
            cmd.emit = 1'b1;
            cmd.evt  = EV_POWER;
            wake_in  = '0;
            state_in = ST_WAKE;
         end
         ST_WAKE: begin
            cmd.emit = 1'b1;
            priority if (!wake_ff[0]) cmd.evt = EV_WAKE_HI;
            else if (wake_ff == 3'd1) cmd.evt = EV_WAKE_LO_FIRST;
            else cmd.evt = EV_WAKE_LO;
            // last wake pulse switches the bus to four bits
            cmd.wake_two = (wake_ff[2:1] == 2'b11);
            wake_in      = wake_ff + 3'd1;
            if (wake_ff == 3'd7) begin
               state_in      = ST_BYTE;
               phase_in      = '0;
               icmd_in       = '0;
               cmd.load_init = 1'b1;
               cmd.init_idx  = '0;
            end
         end
         ST_BYTE: begin
            cmd.emit = 1'b1;
            unique case (phase_ff)
               2'd0: cmd.evt = EV_BYTE_HI_EN;
               2'd1: cmd.evt = EV_BYTE_HI_DIS;
               2'd2: cmd.evt = EV_BYTE_LO_EN;
               2'd3: cmd.evt = EV_BYTE_LO_DIS;
            endcase
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               if (init_ff && (icmd_ff != 2'd3)) begin
                  cmd.load_init = 1'b1;
                  cmd.init_idx  = icmd_ff + 2'd1;
                  icmd_in       = icmd_ff + 2'd1;
               end else begin
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
                  take     = 1'b1;
               end
            end
         end
      endcase
      if (take && start) begin
         if (req_operation == OP_INIT) begin
            state_in = ST_POWER;
            init_in  = 1'b1;
         end else if (req_operation == OP_CMD || req_operation == OP_DATA ||
                      req_operation == OP_GOTO || req_operation == OP_CLEAR) begin
            state_in     = ST_BYTE;
            phase_in     = '0;
            init_in      = 1'b0;
            cmd.load_req = 1'b1;
         end
      end
   end

   assign busy = ~take;

endmodule

[rtl/clcd_dp.sv]
module clcd_dp
   import clcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   input  logic [2:0]         req_operation,
   input  logic [7:0]         req_byte_value,
   input  logic [7:0]         req_row,
   input  logic [7:0]         req_column,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [WAIT_W-1:0]  csr_data,
   output logic               rsp_strobe,
   output logic [3:0]         rsp_nibble,
   output logic               rsp_reg_select,
   output logic               rsp_enable,
   output logic [EVENT_W-1:0] rsp_wait_units,
   output logic               rsp_last
);

   logic [WAIT_W-1:0]  pulse_ff, short_ff, long_ff, powerup_ff, first_wake_ff, wake_ff;
   logic [7:0]         byte_ff, byte_in;
   logic               rs_ff, rs_in;
   extra_type          extra_ff, extra_in;
   logic [3:0]         goto_off;
   logic [7:0]         goto_byte;
   logic [EVENT_W-1:0] extra_val;
   logic [3:0]         nib_in;
   logic               en_in;
   logic               rsel_in;
   logic [EVENT_W-1:0] wait_in;
   logic               strobe_ff;
   logic [3:0]         nib_ff;
   logic               en_ff, rsel_ff, last_ff;
   logic [EVENT_W-1:0] wait_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff      <= 24'd800;
         short_ff      <= 24'd2000;
         long_ff       <= 24'd50000;
         powerup_ff    <= 24'd500000;
         first_wake_ff <= 24'd150000;
         wake_ff       <= 24'd5000;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PULSE_WAIT:      pulse_ff      <= csr_data;
            CSR_SHORT_WAIT:      short_ff      <= csr_data;
            CSR_LONG_WAIT:       long_ff       <= csr_data;
            CSR_POWERUP_WAIT:    powerup_ff    <= csr_data;
            CSR_FIRST_WAKE_WAIT: first_wake_ff <= csr_data;
            CSR_WAKE_WAIT:       wake_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // byte to send and its trailing wait class
   assign goto_off  = req_column[3:0] - 4'd1;
   assign goto_byte = ((req_row == ROW_FIRST) ? DDRAM_LINE0 : DDRAM_LINE1) + {4'd0, goto_off};

   always_comb begin
      byte_in  = byte_ff;
      rs_in    = rs_ff;
      extra_in = extra_ff;
      if (cmd.load_req) begin
         rs_in = 1'b0;
         unique case (req_operation)
            OP_DATA:  byte_in = req_byte_value;
            OP_GOTO:  byte_in = goto_byte;
            OP_CLEAR: byte_in = CMD_CLEAR;
            default:  byte_in = req_byte_value;
         endcase
         if (req_operation == OP_DATA) begin
            rs_in    = 1'b1;
            extra_in = EXTRA_SHORT;
         end else if (req_operation == OP_CLEAR) begin
            extra_in = EXTRA_DOUBLE;
         end else begin
            extra_in = (byte_in < LONG_CMD_LIMIT) ? EXTRA_LONG : EXTRA_SHORT;
         end
      end else if (cmd.load_init) begin
         rs_in    = 1'b0;
         extra_in = EXTRA_SHORT;
         unique case (cmd.init_idx)
            2'd0: byte_in = CMD_FUNC_SET;
            2'd1: byte_in = CMD_DISPLAY_ON;
            2'd2: byte_in = CMD_ENTRY_MODE;
            2'd3: begin
               byte_in  = CMD_CLEAR;
               extra_in = EXTRA_DOUBLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      rs_ff    <= rs_in;
      extra_ff <= extra_in;
   end

   always_comb begin
      unique case (extra_ff)
         EXTRA_SHORT:  extra_val = {2'b00, short_ff};
         EXTRA_LONG:   extra_val = {2'b00, long_ff};
         EXTRA_DOUBLE: extra_val = {1'b0, long_ff, 1'b0};
         default:      extra_val = {2'b00, short_ff};
      endcase
   end

   // pins for the event the controller asks for
   always_comb begin
      nib_in  = byte_ff[7:4];
      rsel_in = rs_ff;
      en_in   = 1'b0;
      wait_in = {2'b00, pulse_ff};
      unique case (cmd.evt)
         EV_POWER: begin
            nib_in  = 4'h0;
            rsel_in = 1'b0;
            wait_in = {2'b00, powerup_ff};
         end
         EV_WAKE_HI: begin
            nib_in  = cmd.wake_two ? WAKE_NIB_4BIT : WAKE_NIB;
            rsel_in = 1'b0;
            en_in   = 1'b1;
         end
         EV_WAKE_LO_FIRST: begin
            nib_in  = WAKE_NIB;
            rsel_in = 1'b0;
            wait_in = {2'b00, first_wake_ff};
         end
         EV_WAKE_LO: begin
            nib_in  = cmd.wake_two ? WAKE_NIB_4BIT : WAKE_NIB;
            rsel_in = 1'b0;
            wait_in = {2'b00, wake_ff};
         end
         EV_BYTE_HI_EN:  en_in = 1'b1;
         EV_BYTE_HI_DIS: en_in = 1'b0;
         EV_BYTE_LO_EN: begin
            nib_in = byte_ff[3:0];
            en_in  = 1'b1;
         end
         EV_BYTE_LO_DIS: begin
            nib_in  = byte_ff[3:0];
            wait_in = {2'b00, pulse_ff} + extra_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         nib_ff  <= nib_in;
         rsel_ff <= rsel_in;
         en_ff   <= en_in;
         wait_ff <= wait_in;
         last_ff <= cmd.last;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_nibble     = nib_ff;
   assign rsp_reg_select = rsel_ff;
   assign rsp_enable     = en_ff;
   assign rsp_wait_units = wait_ff;
   assign rsp_last       = last_ff;

endmodule

[rtl/char_lcd_nibble_sequencer_unit.sv]
// 4-bit character lcd bus sequencer. a request (init, command byte, data
// byte, cursor goto, clear) is taken when start is high and busy is low, and
// turns into a run of pin events, one event per clock on the rsp_ ports,
// each marked by rsp_strobe for a single cycle and the final one by rsp_last.
// the receiver cannot stall: every event must be taken the cycle it shows.
// a byte request gives four events; the next request is taken in the cycle
// that emits the final event, so byte requests run back to back. init gives
// 25 events. a taken request passes the controller state register and then
// the output register before its events appear. operation codes 5 to 7 are
// taken and give nothing.
// the six wait registers are written through the csr_ port, which is always
// ready; write them only while no request is in flight.
module char_lcd_nibble_sequencer_unit
   import clcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [7:0]         req_byte_value,
   input  logic [7:0]         req_row,
   input  logic [7:0]         req_column,
   // pin events
   output logic               rsp_strobe,
   output logic [3:0]         rsp_nibble,
   output logic               rsp_reg_select,
   output logic               rsp_enable,
   output logic [EVENT_W-1:0] rsp_wait_units,
   output logic               rsp_last,
   // wait registers
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [WAIT_W-1:0]  csr_data
);

   ctrl_cmd_type cmd;

   // register writes are not held off while sequencing, so always accept
   assign csr_ready = 1'b1;

   // controller walks power-up, wake pulses and byte phases
   clcd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .busy          (busy),
      .cmd           (cmd)
   );

   // datapath holds the wait registers, the byte in flight and the event register
   clcd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_operation),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .csr_write      (csr_valid & csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_nibble     (rsp_nibble),
      .rsp_reg_select (rsp_reg_select),
      .rsp_enable     (rsp_enable),
      .rsp_wait_units (rsp_wait_units),
      .rsp_last       (rsp_last)
   );

endmodule

[rtl/clcd_chk.sv]
module clcd_chk
   import clcd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [2:0]         req_operation,
   input logic               rsp_strobe,
   input logic               rsp_reg_select,
   input logic               rsp_enable,
   input logic               rsp_last
);

   // a byte request keeps the sequencer busy on the next cycle
   a_busy_after_byte: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_CMD || req_operation == OP_DATA ||
                          req_operation == OP_GOTO || req_operation == OP_CLEAR))
      |=> busy)
      else $error("sequencer idle after byte request");

   // every enable high event is followed at once by an enable low event
   a_pulse_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_enable) |=> (rsp_strobe && !rsp_enable))
      else $error("enable pulse not closed");

   // a run ends with enable low
   a_last_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !rsp_enable)
      else $error("final event with enable high");

   // data requests drive register select high from their first event
   a_data_rs: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_DATA)
      |=> ##1 (rsp_strobe && rsp_reg_select && rsp_enable))
      else $error("data byte without register select");

endmodule

bind char_lcd_nibble_sequencer_unit clcd_chk u_clcd_chk (.*);
